// File: sv/nsc_pkg.sv
// Package for the sentence checker: character codes, field_limit width,
// reset value and bounds, field width and the hex decoder. No dependencies.
`default_nettype none

package nsc_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    localparam int unsigned LIMIT_W     = 7;
    localparam int unsigned FIELD_W     = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd20;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 7'd64;

    // Decoded hex digit: valid flag plus nibble value.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex       res;
        logic [7:0] diff;
        res  = '{valid: 1'b0, value: 4'd0};
        diff = 8'd0;
        if (ch inside {[8'h30:8'h39]}) begin
            diff      = ch - CHAR_ZERO;
            res.valid = 1'b1;
            res.value = diff[3:0];
        end else if (ch inside {[8'h41:8'h46]}) begin
            diff      = ch - CHAR_UC_A + HEX_TEN;
            res.valid = 1'b1;
            res.value = diff[3:0];
        end else if (ch inside {[8'h61:8'h66]}) begin
            diff      = ch - CHAR_LC_A + HEX_TEN;
            res.valid = 1'b1;
            res.value = diff[3:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/nmea_sentence_checker_top.sv
// Top level of the sentence checker: input register, per-byte sentence
// state machine and result register. Depends on nsc_pkg.
`default_nettype none

// Channel   | Handshake                 | Payload
// ----------+---------------------------+--------------------------------------
// rx in     | i_rx_valid / o_rx_ready   | i_rx_byte
// result out| o_res_valid / i_res_ready | o_echo_byte, o_field_number,
//           |                           | o_is_separator, o_is_payload,
//           |                           | o_sentence_done, o_checksum_ok
// config    | i_cfg_we (no wait)        | i_cfg_wdata (field_limit)
//
// Each accepted byte is held in the input register and is then processed
// into the result register once that register is empty or draining; the
// result stays valid there until it is taken. One byte per cycle is
// sustained while the result side keeps taking; the only loop is the
// sentence state (phase, running XOR, field index), updated per byte.
// Reset is synchronous and active low; it clears the handshake flags, the
// sentence state and sets field_limit to 20.
// A stalled output holds its result; the input register takes one more
// transaction while the result waits, then stalls until the result drains.

module nmea_sentence_checker_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output logic [7:0]      o_echo_byte,
    output logic [5:0]      o_field_number,
    output logic            o_is_separator,
    output logic            o_is_payload,
    output logic            o_sentence_done,
    output logic            o_checksum_ok,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        PH_START,
        PH_PAYLOAD,
        PH_HEX1,
        PH_HEX2_OK,
        PH_HEX2_BAD,
        PH_DONE
    } t_phase;

    // Configuration register.
    logic [nsc_pkg::LIMIT_W-1:0] r_field_limit;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Sentence state.
    t_phase                      r_phase;
    logic [7:0]                  r_xor;
    logic [3:0]                  r_high_nibble;
    logic                        r_match;
    logic [nsc_pkg::FIELD_W-1:0] r_field;

    // Result register.
    logic                        r_out_valid;
    logic [7:0]                  r_echo;
    logic [nsc_pkg::FIELD_W-1:0] r_fnum;
    logic                        r_sep;
    logic                        r_pay;
    logic                        r_done;
    logic                        r_ok;

    // Next values.
    t_phase                      n_phase;
    logic [7:0]                  n_xor;
    logic [3:0]                  n_high_nibble;
    logic                        n_match;
    logic [nsc_pkg::FIELD_W-1:0] n_field;
    logic [nsc_pkg::FIELD_W-1:0] n_fnum;
    logic                        n_sep;
    logic                        n_pay;
    logic                        n_done;
    logic                        n_ok;

    logic                        advance;
    logic [nsc_pkg::LIMIT_W-1:0] lim;
    logic [nsc_pkg::LIMIT_W-1:0] field_inc;
    nsc_pkg::t_hex               hex;
    logic                        line_end;

    // The processing step moves the byte from the input register into the
    // result register whenever the result register is empty or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;

    // Limits outside 1..64 are clamped to the nearest end.
    always_comb begin
        if (r_field_limit < nsc_pkg::LIMIT_MIN) begin
            lim = nsc_pkg::LIMIT_MIN;
        end else if (r_field_limit > nsc_pkg::LIMIT_MAX) begin
            lim = nsc_pkg::LIMIT_MAX;
        end else begin
            lim = r_field_limit;
        end
    end

    assign field_inc = {1'b0, r_field} + 7'd1;
    assign hex       = nsc_pkg::hex_decode(r_in_byte);
    assign line_end  = (r_in_byte == nsc_pkg::CHAR_CR) || (r_in_byte == nsc_pkg::CHAR_LF);

    always_comb begin
        n_phase       = r_phase;
        n_xor         = r_xor;
        n_high_nibble = r_high_nibble;
        n_match       = r_match;
        n_field       = r_field;
        n_fnum        = r_field;
        n_sep         = 1'b0;
        n_pay         = 1'b0;
        n_done        = 1'b0;
        n_ok          = 1'b0;
        if (line_end) begin
            // A line end right after another one is an empty line: no done.
            if (r_phase != PH_START) begin
                n_done = 1'b1;
                n_ok   = (r_phase == PH_DONE) && r_match;
            end
            n_phase       = PH_START;
            n_xor         = 8'd0;
            n_high_nibble = 4'd0;
            n_match       = 1'b0;
            n_field       = '0;
        end else begin
            case (r_phase)
                PH_START: begin
                    n_phase = PH_PAYLOAD;
                    n_fnum  = '0;
                end
                PH_PAYLOAD: begin
                    if (r_in_byte == nsc_pkg::CHAR_STAR) begin
                        n_phase = PH_HEX1;
                    end else begin
                        n_pay = 1'b1;
                        n_xor = r_xor ^ r_in_byte;
                        if ((r_in_byte == nsc_pkg::CHAR_COMMA) && (field_inc < lim)) begin
                            n_field = field_inc[nsc_pkg::FIELD_W-1:0];
                            n_fnum  = field_inc[nsc_pkg::FIELD_W-1:0];
                            n_sep   = 1'b1;
                        end
                    end
                end
                PH_HEX1: begin
                    if (hex.valid) begin
                        n_high_nibble = hex.value;
                        n_phase       = PH_HEX2_OK;
                    end else begin
                        n_phase = PH_HEX2_BAD;
                    end
                end
                PH_HEX2_OK: begin
                    n_match = hex.valid && ({r_high_nibble, hex.value} == r_xor);
                    n_phase = PH_DONE;
                end
                PH_HEX2_BAD: begin
                    n_match = 1'b0;
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_limit <= nsc_pkg::LIMIT_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_START;
            r_xor         <= 8'd0;
            r_high_nibble <= 4'd0;
            r_match       <= 1'b0;
            r_field       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_field_limit <= i_cfg_wdata;
            end
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_phase       <= n_phase;
                r_xor         <= n_xor;
                r_high_nibble <= n_high_nibble;
                r_match       <= n_match;
                r_field       <= n_field;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_echo <= r_in_byte;
            r_fnum <= n_fnum;
            r_sep  <= n_sep;
            r_pay  <= n_pay;
            r_done <= n_done;
            r_ok   <= n_ok;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_echo_byte     = r_echo;
    assign o_field_number  = r_fnum;
    assign o_is_separator  = r_sep;
    assign o_is_payload    = r_pay;
    assign o_sentence_done = r_done;
    assign o_checksum_ok   = r_ok;

endmodule

`default_nettype wire

// File: sv/nsc_checker.sv
// Port-level checks for the sentence checker and the bind that attaches
// them to nmea_sentence_checker_top. Depends on nsc_pkg.
`default_nettype none

module nsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_res_valid,
    input wire logic       i_res_ready,
    input wire logic [7:0] o_echo_byte,
    input wire logic       o_is_separator,
    input wire logic       o_is_payload,
    input wire logic       o_sentence_done,
    input wire logic       o_checksum_ok
);

    // A passing checksum is only reported on a completed sentence.
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_checksum_ok) |-> o_sentence_done)
        else $error("checksum_ok without sentence_done");

    // A counted separator is always a comma inside the payload.
    a_sep_is_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_is_separator) |->
            (o_is_payload && (o_echo_byte == nsc_pkg::CHAR_COMMA)))
        else $error("separator flag on a non-payload or non-comma byte");

    // Done is raised only on a line-end character.
    a_done_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_sentence_done) |->
            ((o_echo_byte == nsc_pkg::CHAR_CR) || (o_echo_byte == nsc_pkg::CHAR_LF)))
        else $error("sentence_done on a byte that is not a line end");

    // Payload never includes the asterisk or a line end.
    a_payload_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_is_payload) |->
            ((o_echo_byte != nsc_pkg::CHAR_STAR) && (o_echo_byte != nsc_pkg::CHAR_CR)
             && (o_echo_byte != nsc_pkg::CHAR_LF) && !o_sentence_done))
        else $error("payload flag on a delimiter byte");

    // A stalled result holds.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_echo_byte)))
        else $error("result dropped or changed while stalled");

endmodule

bind nmea_sentence_checker_top nsc_checker u_nsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_res_valid     (o_res_valid),
    .i_res_ready     (i_res_ready),
    .o_echo_byte     (o_echo_byte),
    .o_is_separator  (o_is_separator),
    .o_is_payload    (o_is_payload),
    .o_sentence_done (o_sentence_done),
    .o_checksum_ok   (o_checksum_ok)
);

`default_nettype wire

// File: bench/nsc_line_checker.sv
// Checker for the sentence checker: predicts the tag of every accepted byte
// and compares it, field by field, with each result transaction.
// Depends on nsc_pkg for character codes and field_limit bounds.

module nsc_line_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_echo_byte,
    input  logic [5:0] i_field_number,
    input  logic       i_is_separator,
    input  logic       i_is_payload,
    input  logic       i_sentence_done,
    input  logic       i_checksum_ok,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_checked,
    output int         o_lines_closed,
    output int         o_lines_ok
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] HEX_LETTERS = 8'd6;

    typedef enum logic [2:0] {
        LINE_START,
        IN_BODY,
        WANT_HI,
        WANT_LO,
        WANT_LO_BAD,
        CHECKED
    } t_line_phase;

    typedef struct packed {
        logic [7:0] echo;
        logic [5:0] field;
        logic       sep;
        logic       pay;
        logic       done;
        logic       ok;
    } t_byte_tag;

    t_line_phase phase;
    logic [7:0]  body_xor;
    logic [3:0]  hi_nibble;
    logic        sum_matches;
    logic [5:0]  field_idx;
    logic [6:0]  field_limit;
    t_byte_tag   tags_due[$];
    int          mismatches = 0;
    int          checked    = 0;
    int          closed     = 0;
    int          good       = 0;

    // Returns {valid, value} for a hex digit in either letter case.
    function automatic logic [4:0] decode_hex(input logic [7:0] ch);
        if (ch >= nsc_pkg::CHAR_ZERO && ch < nsc_pkg::CHAR_ZERO + nsc_pkg::HEX_TEN) begin
            return {1'b1, 4'(ch - nsc_pkg::CHAR_ZERO)};
        end
        if (ch >= nsc_pkg::CHAR_UC_A && ch < nsc_pkg::CHAR_UC_A + HEX_LETTERS) begin
            return {1'b1, 4'(ch - nsc_pkg::CHAR_UC_A + nsc_pkg::HEX_TEN)};
        end
        if (ch >= nsc_pkg::CHAR_LC_A && ch < nsc_pkg::CHAR_LC_A + HEX_LETTERS) begin
            return {1'b1, 4'(ch - nsc_pkg::CHAR_LC_A + nsc_pkg::HEX_TEN)};
        end
        return 5'd0;
    endfunction

    task automatic clear_line();
        phase       = LINE_START;
        body_xor    = 8'd0;
        hi_nibble   = 4'd0;
        sum_matches = 1'b0;
        field_idx   = 6'd0;
    endtask

    // Advances the sentence state by one byte and returns the expected tag.
    task automatic tag_byte(input logic [7:0] b, output t_byte_tag t);
        logic [6:0] lim;
        logic [4:0] nib;
        lim = field_limit;
        if (lim < nsc_pkg::LIMIT_MIN) lim = nsc_pkg::LIMIT_MIN;
        if (lim > nsc_pkg::LIMIT_MAX) lim = nsc_pkg::LIMIT_MAX;
        t       = '0;
        t.echo  = b;
        t.field = field_idx;
        if (b == nsc_pkg::CHAR_CR || b == nsc_pkg::CHAR_LF) begin
            if (phase != LINE_START) begin
                t.done = 1'b1;
                t.ok   = (phase == CHECKED) && sum_matches;
            end
            clear_line();
        end else begin
            case (phase)
                LINE_START: begin
                    phase   = IN_BODY;
                    t.field = 6'd0;
                end
                IN_BODY: begin
                    if (b == nsc_pkg::CHAR_STAR) begin
                        phase = WANT_HI;
                    end else begin
                        t.pay    = 1'b1;
                        body_xor = body_xor ^ b;
                        // Commas past the last field stay in it as plain data.
                        if (b == nsc_pkg::CHAR_COMMA && ({1'b0, field_idx} + 7'd1) < lim) begin
                            field_idx = field_idx + 6'd1;
                            t.sep     = 1'b1;
                        end
                        t.field = field_idx;
                    end
                end
                WANT_HI: begin
                    nib = decode_hex(b);
                    if (nib[4]) begin
                        hi_nibble = nib[3:0];
                        phase     = WANT_LO;
                    end else begin
                        phase = WANT_LO_BAD;
                    end
                end
                WANT_LO: begin
                    nib         = decode_hex(b);
                    sum_matches = nib[4] && ({hi_nibble, nib[3:0]} == body_xor);
                    phase       = CHECKED;
                end
                WANT_LO_BAD: begin
                    sum_matches = 1'b0;
                    phase       = CHECKED;
                end
                default: begin
                    phase = CHECKED;
                end
            endcase
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_byte_tag want;
        if (!i_rst_n) begin
            clear_line();
            field_limit = nsc_pkg::LIMIT_RESET;
            tags_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (tags_due.size() == 0) begin
                    $error("unexpected result transaction, echo_byte %0h", i_echo_byte);
                    mismatches++;
                end else begin
                    want = tags_due.pop_front();
                    checked++;
                    if (want.done) closed++;
                    if (want.done && want.ok) good++;
                    compare_field("echo_byte", want.echo, i_echo_byte);
                    compare_field("field_number", want.field, i_field_number);
                    compare_field("is_separator", want.sep, i_is_separator);
                    compare_field("is_payload", want.pay, i_is_payload);
                    compare_field("sentence_done", want.done, i_sentence_done);
                    compare_field("checksum_ok", want.ok, i_checksum_ok);
                end
            end
            if (i_cfg_we) begin
                field_limit = i_cfg_wdata;
            end
            if (i_rx_valid && i_rx_ready) begin
                tag_byte(i_rx_byte, want);
                tags_due.push_back(want);
            end
        end
        o_pending      <= tags_due.size();
        o_mismatches   <= mismatches;
        o_checked      <= checked;
        o_lines_closed <= closed;
        o_lines_ok     <= good;
    end

endmodule

// File: bench/tb_top.sv
// Top of the sentence checker testbench: clock, reset, byte stimulus, result
// sink with random back-pressure, watchdog and verdict.
// Depends on nsc_pkg, nmea_sentence_checker_top and nsc_line_checker.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Common start delimiters of a sentence.
    localparam logic [7:0] START_DOLLAR = 8'h24;
    localparam logic [7:0] START_BANG   = 8'h21;

    // Random part: number of field_limit settings and minimum bytes sent under each.
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 40;
    // The long receiver hold-off, and the watchdog limit on cycles in which
    // neither channel completes a transaction. The limit sits well above the
    // longest stall that a correct run can see.
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [6:0] i_cfg_wdata = 7'd0;

    logic       o_rx_ready;
    logic       o_res_valid;
    logic [7:0] o_echo_byte;
    logic [5:0] o_field_number;
    logic       o_is_separator;
    logic       o_is_payload;
    logic       o_sentence_done;
    logic       o_checksum_ok;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int closed_count;
    int good_count;

    // Knobs shared by the byte sender and the result sink. The sink clears
    // hold_req itself once it has held ready low for the long stretch.
    bit sender_steady = 1'b0;
    bit sink_steady   = 1'b0;
    bit hold_req      = 1'b0;
    int items_sent    = 0;

    // Bytes of the line being sent.
    logic [7:0] line_q[$];

    nmea_sentence_checker_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_echo_byte     (o_echo_byte),
        .o_field_number  (o_field_number),
        .o_is_separator  (o_is_separator),
        .o_is_payload    (o_is_payload),
        .o_sentence_done (o_sentence_done),
        .o_checksum_ok   (o_checksum_ok),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    nsc_line_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .i_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .i_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .i_echo_byte     (o_echo_byte),
        .i_field_number  (o_field_number),
        .i_is_separator  (o_is_separator),
        .i_is_payload    (o_is_payload),
        .i_sentence_done (o_sentence_done),
        .i_checksum_ok   (o_checksum_ok),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_mismatches    (mismatch_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count),
        .o_lines_closed  (closed_count),
        .o_lines_ok      (good_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Length of an idle stretch: a short one with a chance of short_pct percent, else a long one.
    function automatic int idle_len(input int short_pct);
        if ($urandom_range(0, 99) < short_pct) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Any character but a line end; the asterisk only when allowed.
    function automatic logic [7:0] random_char(input bit allow_star);
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(0, 255));
        end while (ch == nsc_pkg::CHAR_CR || ch == nsc_pkg::CHAR_LF
                   || (!allow_star && ch == nsc_pkg::CHAR_STAR));
        return ch;
    endfunction

    // One payload character. Commas come often so that the field index
    // climbs to the limit; a few characters are arbitrary bytes.
    function automatic logic [7:0] body_char(input int comma_pct);
        int         r;
        logic [7:0] ch;
        r = $urandom_range(0, 99);
        if (r < comma_pct) begin
            return nsc_pkg::CHAR_COMMA;
        end
        if (r < 90) begin
            ch = 8'($urandom_range(8'h20, 8'h7E));
            return (ch == nsc_pkg::CHAR_STAR) ? nsc_pkg::CHAR_COMMA : ch;
        end
        return random_char(1'b0);
    endfunction

    // Hex digit for a nibble, letters in a random case.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < nsc_pkg::HEX_TEN) begin
            return nsc_pkg::CHAR_ZERO + nib;
        end
        return ($urandom_range(0, 1) ? nsc_pkg::CHAR_UC_A : nsc_pkg::CHAR_LC_A)
               + (nib - 4'd10);
    endfunction

    // A character that is neither a hex digit nor a line end.
    function automatic logic [7:0] bad_hex_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h3A, 8'h40));
            1:       return 8'($urandom_range(8'h47, 8'h60));
            2:       return 8'($urandom_range(8'h67, 8'hFF));
            default: return 8'($urandom_range(8'h0E, 8'h2F));
        endcase
    endfunction

    // Sender gap after a transaction: none in steady stretches, otherwise
    // often none and sometimes short or long.
    function automatic int sender_gap();
        if (sender_steady || $urandom_range(0, 99) < 55) begin
            return 0;
        end
        return idle_len(75);
    endfunction

    // Offers one byte and holds it until accepted. Valid is only lowered
    // when a gap follows, so back-to-back bytes keep valid high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do begin
            @(posedge i_clk);
        end while (!o_rx_ready);
        items_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_line();
        foreach (line_q[i]) begin
            send_byte(line_q[i]);
        end
    endtask

    // Stops offering bytes and waits until every expected result has come.
    // The first edge lets the checker count a byte accepted just now.
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_count != 0);
    endtask

    // Writes field_limit; only called while the block is idle.
    task automatic write_limit(input logic [6:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Builds a sentence with random content. Most carry a correct checksum,
    // some with extra bytes trailing it; the rest lack the asterisk, stop
    // short, or carry a bad hex digit or a wrong sum.
    task automatic make_sentence(input bit force_long);
        int         body_len;
        int         comma_pct;
        int         kind;
        logic [7:0] body_sum;
        logic [7:0] ch;
        line_q.delete();
        case ($urandom_range(0, 9))
            0:       line_q.push_back(random_char(1'b1));
            1, 2, 3: line_q.push_back(START_BANG);
            default: line_q.push_back(START_DOLLAR);
        endcase
        // Long comma-heavy bodies push the field index to the top of its range.
        if (force_long || $urandom_range(0, 11) == 0) begin
            body_len  = $urandom_range(60, 80);
            comma_pct = 85;
        end else begin
            body_len  = $urandom_range(0, 24);
            comma_pct = 30;
        end
        body_sum = 8'd0;
        for (int i = 0; i < body_len; i++) begin
            ch       = body_char(comma_pct);
            body_sum = body_sum ^ ch;
            line_q.push_back(ch);
        end
        kind = $urandom_range(0, 99);
        if (kind >= 6) begin
            line_q.push_back(nsc_pkg::CHAR_STAR);
            if (kind < 10) begin
                // Line ends right after the asterisk.
            end else if (kind < 14) begin
                line_q.push_back(hex_char(body_sum[7:4]));
            end else if (kind < 20) begin
                line_q.push_back(bad_hex_char());
                line_q.push_back(hex_char(body_sum[3:0]));
            end else if (kind < 26) begin
                line_q.push_back(hex_char(body_sum[7:4]));
                line_q.push_back(bad_hex_char());
            end else if (kind < 34) begin
                body_sum = body_sum ^ (8'd1 << $urandom_range(0, 7));
                line_q.push_back(hex_char(body_sum[7:4]));
                line_q.push_back(hex_char(body_sum[3:0]));
            end else begin
                line_q.push_back(hex_char(body_sum[7:4]));
                line_q.push_back(hex_char(body_sum[3:0]));
                if (kind >= 88) begin
                    repeat ($urandom_range(1, 4)) line_q.push_back(random_char(1'b1));
                end
            end
        end
        case ($urandom_range(0, 3))
            0: begin
                line_q.push_back(nsc_pkg::CHAR_CR);
                line_q.push_back(nsc_pkg::CHAR_LF);
            end
            1: line_q.push_back(nsc_pkg::CHAR_LF);
            2: line_q.push_back(nsc_pkg::CHAR_CR);
            default: begin
                line_q.push_back(nsc_pkg::CHAR_LF);
                line_q.push_back(nsc_pkg::CHAR_CR);
            end
        endcase
    endtask

    // Mostly well-formed sentences; now and then empty lines or a burst of
    // arbitrary bytes, which may leave the next line starting mid-sentence.
    task automatic send_random_line(input bit force_long);
        int r;
        r = $urandom_range(0, 99);
        if (force_long || r < 85) begin
            make_sentence(force_long);
        end else if (r < 90) begin
            line_q.delete();
            repeat ($urandom_range(1, 2)) begin
                line_q.push_back($urandom_range(0, 1) ? nsc_pkg::CHAR_CR : nsc_pkg::CHAR_LF);
            end
        end else begin
            line_q.delete();
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 7) line_q.push_back(nsc_pkg::CHAR_LF);
        end
        send_line();
    endtask

    // Field limits to visit: the extremes and values next to them, the
    // out-of-range values that clamp, and a couple of random ones at the end.
    function automatic logic [6:0] limit_for_phase(input int p);
        case (p)
            0:       return nsc_pkg::LIMIT_MIN;
            1:       return 7'd0;
            2:       return nsc_pkg::LIMIT_MAX;
            3:       return 7'd127;
            4:       return 7'd2;
            5:       return 7'd65;
            6:       return 7'd63;
            7:       return 7'd3;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // Result sink: alternates ready and stall stretches of random length,
    // stays ready in steady stretches, and on request holds ready low for a
    // long count of cycles so that the block fills up and stalls its input.
    initial begin : result_sink
        int run;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                run      = 0;
            end else if (sink_steady) begin
                i_res_ready <= 1'b1;
            end else if (run > 0) begin
                run--;
            end else if ($urandom_range(0, 2) != 0) begin
                i_res_ready <= 1'b1;
                run = $urandom_range(0, 20);
            end else begin
                i_res_ready <= 1'b0;
                run = idle_len(80);
            end
        end
    end

    // Watchdog: ends the run as a fail when no transaction completes on either
    // channel for a stretch that reaches the STALL_LIMIT bound; any transaction restarts it.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("nmea_sentence_checker_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        int phase_start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines at the reset field_limit. An empty line gives no
        // done, and CR LF after a sentence gives one done, on the CR.
        line_q = '{nsc_pkg::CHAR_LF};
        send_line();
        // Matching all-digit checksum.
        line_q = '{START_DOLLAR, "A", nsc_pkg::CHAR_STAR, "4", "1",
                   nsc_pkg::CHAR_CR, nsc_pkg::CHAR_LF};
        send_line();
        // Odd start delimiter, lowercase checksum, then a trailing byte.
        line_q = '{8'hFF, "J", nsc_pkg::CHAR_STAR, "4", "a", "z", nsc_pkg::CHAR_LF};
        send_line();
        // A zero byte in the payload, then an invalid first hex digit.
        line_q = '{START_BANG, 8'h00, nsc_pkg::CHAR_STAR, "G", nsc_pkg::CHAR_LF};
        send_line();
        // No asterisk: an all-ones byte and a separator, then the line end.
        line_q = '{START_DOLLAR, 8'hFF, nsc_pkg::CHAR_COMMA, nsc_pkg::CHAR_CR};
        send_line();
        // Empty payload with an invalid second hex digit.
        line_q = '{START_DOLLAR, nsc_pkg::CHAR_STAR, "0", "x", nsc_pkg::CHAR_CR};
        send_line();

        // Random part: one field_limit setting per phase, each written only
        // after the sender has paused and every expected result has come.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_limit(limit_for_phase(p));
            // One phase runs with no idling on either side.
            sender_steady = (p == 2);
            sink_steady   = (p == 2);
            // In another the sink holds off while the sender keeps offering.
            if (p == 4) hold_req = 1'b1;
            phase_start = items_sent;
            // With the widest limits, open with a long comma-heavy sentence
            // so that the field index reaches its top value.
            send_random_line(limit_for_phase(p) >= 7'd63 && p < 8);
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_line(1'b0);
            end
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes across the reset field_limit and %0d written settings;",
                 items_sent, PHASES);
        $display("checked %0d result transactions, %0d sentences closed, %0d with a good sum.",
                 checked_count, closed_count, good_count);
        if (pending_count != 0) begin
            $error("%0d expected results never arrived", pending_count);
        end
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("nmea_sentence_checker_top regression: pass");
        end else begin
            $display("nmea_sentence_checker_top regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/nsc_pkg.sv
sv/nmea_sentence_checker_top.sv
sv/nsc_checker.sv
bench/nsc_line_checker.sv
bench/tb_top.sv
